[hdl/hcb_pkg.sv]
// ---------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the HSV colour blender: component formats,
// hue sector size, divider shape and queue status.
// ---------------------------------------------------------------------------
package hcb_pkg;

	// fixed point formats
	localparam int COMP_W            = 17;          // hue, saturation and value width
	localparam int COLOR_W           = 24;
	localparam int FRAC_IN_W         = 17;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 8;

	localparam logic [COMP_W-1:0] UNIT     = 17'd65536;
	localparam logic [COMP_W-1:0] SECTOR   = 17'd15360;
	localparam logic [COMP_W-1:0] HUE_TURN = 17'd92160;

	// pipelined divider: 8-bit divisor, six quotient bits per stage
	localparam int DIV_NUM_W  = 25;
	localparam int DIV_DEN_W  = 8;
	localparam int DIV_STAGES = 3;
	localparam int DIV_STEPS  = 6;
	localparam int DIV_Q_W    = DIV_STAGES * DIV_STEPS;

	typedef struct packed {
		logic [COMP_W-1:0] h;
		logic [COMP_W-1:0] s;
		logic [COMP_W-1:0] v;
	} hcb_hsv_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hcb_fifo_stat_t;

endpackage

[hdl/hsv_color_blender.sv]
// ---------------------------------------------------------------------------
// hsv_color_blender
// Blends two RGB colours in HSV space by a saturated fraction.
//
//   channel   signals                                        direction
//   command   start, busy, first_color, second_color,        in
//             blend_fraction
//   result    strobe, blended_color                          out
//
// One transaction is taken per cycle while busy is low; the strobe
// follows through the front, the queue read and the back pipeline.
// The top level holds a credit count over the front and the queue, so
// busy rises once QUEUE_DEPTH transactions are in flight; a free-running
// back keeps at most six in flight, so with the default depth busy never
// rises. Reset clears all valid bits and the queue.
// Results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
module hsv_color_blender #(
	parameter int FRACTION_BITS = hcb_pkg::FRACTION_BITS_DEF,
	parameter int QUEUE_DEPTH   = hcb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [hcb_pkg::COLOR_W-1:0]     first_color,
	input  logic [hcb_pkg::COLOR_W-1:0]     second_color,
	input  logic [hcb_pkg::FRAC_IN_W-1:0]   blend_fraction,
	output logic                            strobe,
	output logic [hcb_pkg::COLOR_W-1:0]     blended_color
);
	import hcb_pkg::*;

	localparam int TW = FRACTION_BITS + 1;
	localparam int EW = 2 * $bits(hcb_hsv_t) + TW;
	localparam int CRW = $clog2(QUEUE_DEPTH + 1);

	logic           accept;
	logic           front_valid;
	hcb_hsv_t       front_hsv1, front_hsv2, back_hsv1, back_hsv2;
	logic [TW-1:0]  front_t, back_t;
	logic [EW-1:0]  q_wdata, q_rdata;
	logic           q_pop, q_rvalid;
	hcb_fifo_stat_t fifo_stat;
	logic [CRW-1:0] credit_q;

	assign accept = start && !busy;

	hcb_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (accept),
		.first_color    (first_color),
		.second_color   (second_color),
		.blend_fraction (blend_fraction),
		.out_valid      (front_valid),
		.out_hsv1       (front_hsv1),
		.out_hsv2       (front_hsv2),
		.out_t          (front_t)
	);

	assign q_wdata = {front_hsv1, front_hsv2, front_t};
	assign q_pop   = !fifo_stat.empty;

	hcb_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_valid (q_rvalid),
		.pop_data  (q_rdata),
		.stat      (fifo_stat)
	);

	assign {back_hsv1, back_hsv2, back_t} = q_rdata;

	hcb_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_rvalid),
		.in_hsv1   (back_hsv1),
		.in_hsv2   (back_hsv2),
		.in_t      (back_t),
		.out_valid (strobe),
		.out_color (blended_color)
	);

	// credits: transactions in the front or waiting in the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !q_pop) begin
			credit_q <= credit_q + CRW'(1);
		end else if (q_pop && !accept) begin
			credit_q <= credit_q - CRW'(1);
		end
	end

	assign busy = (credit_q == CRW'(QUEUE_DEPTH));

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid |-> !fifo_stat.full)
		else $error("queue written while full");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CRW'(QUEUE_DEPTH))
		else $error("credit count beyond queue depth");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(credit_q == '0) |-> !front_valid)
		else $error("front output with no transaction in flight");

endmodule

[hdl/hcb_div.sv]
// ---------------------------------------------------------------------------
// hcb_div
// Pipelined restoring divider. The top bits of the numerator must already be
// below the divisor, so the quotient fits in DIV_Q_W bits.
// ---------------------------------------------------------------------------
module hcb_div (
	input  logic                             clk,
	input  logic [hcb_pkg::DIV_NUM_W-1:0]    num,
	input  logic [hcb_pkg::DIV_DEN_W-1:0]    den,
	output logic [hcb_pkg::DIV_Q_W-1:0]      quo
);
	import hcb_pkg::*;

	logic [DIV_DEN_W-1:0] rem_s [DIV_STAGES+1];
	logic [DIV_Q_W-1:0]   low_s [DIV_STAGES+1];
	logic [DIV_Q_W-1:0]   quo_s [DIV_STAGES+1];
	logic [DIV_DEN_W-1:0] den_s [DIV_STAGES+1];

	// stage zero taps
	assign rem_s[0] = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
	assign low_s[0] = num[DIV_Q_W-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DIV_DEN_W-1:0] rem_n;
		logic [DIV_Q_W-1:0]   low_n;
		logic [DIV_Q_W-1:0]   quo_n;
		logic [DIV_DEN_W:0]   trial;

		// six shift and subtract steps
		always_comb begin
			rem_n = rem_s[k];
			low_n = low_s[k];
			quo_n = quo_s[k];
			trial = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				trial = {rem_n, low_n[DIV_Q_W-1]};
				low_n = {low_n[DIV_Q_W-2:0], 1'b0};
				if (trial >= {1'b0, den_s[k]}) begin
					rem_n = DIV_DEN_W'(trial - {1'b0, den_s[k]});
					quo_n = {quo_n[DIV_Q_W-2:0], 1'b1};
				end else begin
					rem_n = trial[DIV_DEN_W-1:0];
					quo_n = {quo_n[DIV_Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= rem_n;
			low_s[k+1] <= low_n;
			quo_s[k+1] <= quo_n;
			den_s[k+1] <= den_s[k];
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule

[hdl/hcb_front.sv]
// ---------------------------------------------------------------------------
// hcb_front
// Accepts a colour pair, saturates the fraction and converts both colours
// to hue, saturation and value.
// ---------------------------------------------------------------------------
module hcb_front #(
	parameter int FRACTION_BITS = hcb_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [hcb_pkg::COLOR_W-1:0]       first_color,
	input  logic [hcb_pkg::COLOR_W-1:0]       second_color,
	input  logic [hcb_pkg::FRAC_IN_W-1:0]     blend_fraction,
	output logic                              out_valid,
	output hcb_pkg::hcb_hsv_t                 out_hsv1,
	output hcb_pkg::hcb_hsv_t                 out_hsv2,
	output logic [FRACTION_BITS:0]            out_t
);
	import hcb_pkg::*;

	localparam int TW = FRACTION_BITS + 1;
	localparam int CW = (TW > FRAC_IN_W) ? TW : FRAC_IN_W;

	logic [COLOR_W-1:0] col_s1 [2];
	logic [TW-1:0]      t_s1, t_s2, t_s3, t_s4, t_s5;
	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [CW-1:0]      t_ext, one_ext, t_sat;
	hcb_hsv_t           hsv_res [2];

	// fraction saturation
	always_comb begin
		t_ext   = CW'(blend_fraction);
		one_ext = CW'(1) << FRACTION_BITS;
		t_sat   = (t_ext > one_ext) ? one_ext : t_ext;
	end

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// input capture and fraction delay
	always_ff @(posedge clk) begin
		col_s1[0] <= first_color;
		col_s1[1] <= second_color;
		t_s1      <= t_sat[TW-1:0];
		t_s2      <= t_s1;
		t_s3      <= t_s2;
		t_s4      <= t_s3;
		t_s5      <= t_s4;
	end

	for (genvar c = 0; c < 2; c++) begin : g_conv
		logic [7:0]            r, g, b, mx, mn, d;
		logic [10:0]           n;
		logic [10:0]           n_s2;
		logic [7:0]            d_s2, mx_s2;
		logic [COMP_W-1:0]     v_cur;
		logic [COMP_W-1:0]     v_s3, v_s4, v_s5;
		logic                  dz_s3, dz_s4, dz_s5, mz_s3, mz_s4, mz_s5;
		logic [DIV_NUM_W-1:0]  num_h, num_s;
		logic [DIV_Q_W-1:0]    q_h, q_s;
		logic [COMP_W-1:0]     h_raw;

		// max, min and sextant numerator
		always_comb begin
			r  = col_s1[c][23:16];
			g  = col_s1[c][15:8];
			b  = col_s1[c][7:0];
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			if (r == mx) begin
				n = (g >= b) ? 11'(g - b) : 11'(11'(g) + 11'(6) * 11'(d) - 11'(b));
			end else if (g == mx) begin
				n = 11'(11'(b) + 11'({d, 1'b0}) - 11'(r));
			end else begin
				n = 11'(11'(r) + 11'({d, 2'b00}) - 11'(g));
			end
		end

		always_ff @(posedge clk) begin
			n_s2  <= n;
			d_s2  <= d;
			mx_s2 <= mx;
		end

		// value is 257 * max + 1 for a nonzero max, the rounded-up scale to Q1.16
		always_comb begin
			v_cur = (mx_s2 == 8'd0) ? '0 : COMP_W'({mx_s2, mx_s2}) + COMP_W'(1);
			num_h = (DIV_NUM_W'(n_s2) << 14) - (DIV_NUM_W'(n_s2) << 10);
			num_s = DIV_NUM_W'(d_s2) << 16;
		end

		hcb_div u_div_h (.clk(clk), .num(num_h), .den(d_s2),  .quo(q_h));
		hcb_div u_div_s (.clk(clk), .num(num_s), .den(mx_s2), .quo(q_s));

		// sideband alongside the dividers
		always_ff @(posedge clk) begin
			v_s3  <= v_cur;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			dz_s3 <= (d_s2 == 8'd0);
			dz_s4 <= dz_s3;
			dz_s5 <= dz_s4;
			mz_s3 <= (mx_s2 == 8'd0);
			mz_s4 <= mz_s3;
			mz_s5 <= mz_s4;
		end

		// grey gives hue zero, black gives saturation zero
		always_comb begin
			h_raw = q_h[COMP_W-1:0];
			if (h_raw >= HUE_TURN) h_raw = h_raw - HUE_TURN;
			hsv_res[c].h = dz_s5 ? '0 : h_raw;
			hsv_res[c].s = mz_s5 ? '0 : q_s[COMP_W-1:0];
			hsv_res[c].v = v_s5;
		end
	end

	assign out_valid = valid_s5;
	assign out_hsv1  = hsv_res[0];
	assign out_hsv2  = hsv_res[1];
	assign out_t     = t_s5;

endmodule

[hdl/hcb_fifo.sv]
// ---------------------------------------------------------------------------
// hcb_fifo
// Short queue between the conversion front and the blending back, with a
// registered read port.
// ---------------------------------------------------------------------------
module hcb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hcb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [WIDTH-1:0]        push_data,
	input  logic                    pop,
	output logic                    pop_valid,
	output logic [WIDTH-1:0]        pop_data,
	output hcb_pkg::hcb_fifo_stat_t stat
);
	import hcb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
			pop_valid <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)      count_q <= count_q + NW'(1);
			else if (pop && !push) count_q <= count_q - NW'(1);
			pop_valid <= pop;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
		if (pop)  pop_data      <= mem[rd_ptr_q];
	end

	assign stat.full  = (count_q == NW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

[hdl/hcb_back.sv]
// ---------------------------------------------------------------------------
// hcb_back
// Blends the two HSV triples and converts the result back to packed RGB
// through the six-sector rule.
// ---------------------------------------------------------------------------
module hcb_back #(
	parameter int FRACTION_BITS = hcb_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  hcb_pkg::hcb_hsv_t             in_hsv1,
	input  hcb_pkg::hcb_hsv_t             in_hsv2,
	input  logic [FRACTION_BITS:0]        in_t,
	output logic                          out_valid,
	output logic [hcb_pkg::COLOR_W-1:0]   out_color
);
	import hcb_pkg::*;

	localparam int TW = FRACTION_BITS + 1;
	localparam int PW = COMP_W + TW + 1;
	localparam logic [TW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [24:0]   RECIP15 = 25'd17895698;

	function automatic logic [COMP_W-1:0] mix(input logic [COMP_W-1:0] a,
	                                          input logic [COMP_W-1:0] b,
	                                          input logic [TW-1:0] t);
		logic [PW-1:0] acc;
		acc = PW'(a) * PW'(ONE - t) + PW'(b) * PW'(t);
		return COMP_W'(acc >> FRACTION_BITS);
	endfunction

	function automatic logic [7:0] chan8(input logic [COMP_W-1:0] x);
		logic [24:0] w;
		w = 25'({x, 8'b0}) - 25'(x);
		return w[23:16];
	endfunction

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [COMP_W-1:0] h_s1, s_s1, v_s1;
	logic [2:0]        sec, i_s2, i_s3, i_s4, i_s5;
	logic [COMP_W-1:0] base;
	logic [13:0]       f_s2;
	logic [COMP_W-1:0] s_s2, v_s2, p_s2, s_s3, v_s3, p_s3, s_s4, v_s4, p_s4, v_s5, p_s5;
	logic [33:0]       p_prod;
	logic [30:0]       sfp_s3;
	logic [45:0]       sf_prod;
	logic [COMP_W-1:0] sf_s4;
	logic [33:0]       q_prod;
	logic [34:0]       u_prod;
	logic [17:0]       u_fac;
	logic [COMP_W-1:0] q_s5, u_s5;
	logic [COMP_W-1:0] rr, gg, bb;

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// linear blend of each component
	always_ff @(posedge clk) begin
		h_s1 <= mix(in_hsv1.h, in_hsv2.h, in_t);
		s_s1 <= mix(in_hsv1.s, in_hsv2.s, in_t);
		v_s1 <= mix(in_hsv1.v, in_hsv2.v, in_t);
	end

	// sector, offset in sector and p term
	always_comb begin
		if (h_s1 >= 17'd76800) begin
			sec = 3'd5; base = 17'd76800;
		end else if (h_s1 >= 17'd61440) begin
			sec = 3'd4; base = 17'd61440;
		end else if (h_s1 >= 17'd46080) begin
			sec = 3'd3; base = 17'd46080;
		end else if (h_s1 >= 17'd30720) begin
			sec = 3'd2; base = 17'd30720;
		end else if (h_s1 >= SECTOR) begin
			sec = 3'd1; base = SECTOR;
		end else begin
			sec = 3'd0; base = '0;
		end
		p_prod = 34'(v_s1) * 34'(UNIT - s_s1);
	end

	always_ff @(posedge clk) begin
		i_s2 <= sec;
		f_s2 <= 14'(h_s1 - base);
		s_s2 <= s_s1;
		v_s2 <= v_s1;
		p_s2 <= p_prod[32:16];
	end

	// saturation times offset
	always_ff @(posedge clk) begin
		sfp_s3 <= 31'(s_s2) * 31'(f_s2);
		i_s3   <= i_s2;
		s_s3   <= s_s2;
		v_s3   <= v_s2;
		p_s3   <= p_s2;
	end

	// divide by sector size: shift by 1024, then reciprocal of 15
	assign sf_prod = 46'(sfp_s3[30:10]) * 46'(RECIP15);

	always_ff @(posedge clk) begin
		sf_s4 <= COMP_W'(sf_prod >> 28);
		i_s4  <= i_s3;
		s_s4  <= s_s3;
		v_s4  <= v_s3;
		p_s4  <= p_s3;
	end

	// q and rising terms
	always_comb begin
		q_prod = 34'(v_s4) * 34'(UNIT - sf_s4);
		u_fac  = 18'(UNIT) - 18'(s_s4) + 18'(sf_s4);
		u_prod = 35'(v_s4) * 35'(u_fac);
	end

	always_ff @(posedge clk) begin
		q_s5 <= q_prod[32:16];
		u_s5 <= u_prod[32:16];
		i_s5 <= i_s4;
		v_s5 <= v_s4;
		p_s5 <= p_s4;
	end

	// sector selection and channel scaling
	always_comb begin
		case (i_s5)
			3'd0:    begin rr = v_s5; gg = u_s5; bb = p_s5; end
			3'd1:    begin rr = q_s5; gg = v_s5; bb = p_s5; end
			3'd2:    begin rr = p_s5; gg = v_s5; bb = u_s5; end
			3'd3:    begin rr = p_s5; gg = q_s5; bb = v_s5; end
			3'd4:    begin rr = u_s5; gg = p_s5; bb = v_s5; end
			default: begin rr = v_s5; gg = p_s5; bb = q_s5; end
		endcase
	end

	always_ff @(posedge clk) begin
		out_color <= {chan8(rr), chan8(gg), chan8(bb)};
	end

	assign out_valid = valid_s6;

endmodule

[dv/hsv_color_blender_test.sv]
// ---------------------------------------------------------------------------
// hsv_color_blender_test
// Self-checking testbench for the HSV colour blender. A table of directed
// transactions (extremes, greys, black, each hue sector, fraction saturation)
// is followed by random colour pairs and fractions. Every accepted
// transaction is run through a local HSV predictor and the blended colour
// is compared with the strobed result in order.
// ---------------------------------------------------------------------------
module hsv_color_blender_test;

	import hcb_pkg::*;

	localparam int FBITS      = 16;
	localparam int N_RANDOM   = 1450;
	localparam int WATCHDOG   = 20000;
	localparam int DRAIN_WAIT = 40;

	typedef struct {
		logic [COLOR_W-1:0]   c1;
		logic [COLOR_W-1:0]   c2;
		logic [FRAC_IN_W-1:0] t;
		logic                 known;
		logic [COLOR_W-1:0]   res;
	} blend_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [COLOR_W-1:0]   first_color;
	logic [COLOR_W-1:0]   second_color;
	logic [FRAC_IN_W-1:0] blend_fraction;
	logic                 strobe;
	logic [COLOR_W-1:0]   blended_color;

	logic [COLOR_W-1:0] expected_colors[$];
	int                 fail_count;
	int                 idle_cycles;
	bit                 stim_done;

	hsv_color_blender #(.FRACTION_BITS(FBITS)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_color(first_color), .second_color(second_color),
		.blend_fraction(blend_fraction), .strobe(strobe),
		.blended_color(blended_color)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// packed colour to hue, saturation and value
	function automatic hcb_hsv_t hsv_of_color(logic [COLOR_W-1:0] rgb);
		longint r, g, b, mx, mn, d, n, h;
		hcb_hsv_t o;
		r = rgb[23:16];
		g = rgb[15:8];
		b = rgb[7:0];
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		o.v = COMP_W'((mx * 65536 + 254) / 255);
		o.s = COMP_W'((mx > 0) ? (d * 65536) / mx : 0);
		h = 0;
		if (d != 0) begin
			if (r == mx) n = (g >= b) ? g - b : g + 6 * d - b;
			else if (g == mx) n = b + 2 * d - r;
			else n = r + 4 * d - g;
			h = (15360 * n) / d;
			if (h >= 92160) h -= 92160;
		end
		o.h = COMP_W'(h);
		return o;
	endfunction

	function automatic longint to_chan(longint x);
		longint c;
		c = (x * 255) >> 16;
		return (c > 255) ? 255 : c;
	endfunction

	// full blend of one transaction
	function automatic logic [COLOR_W-1:0] blend_colors(logic [COLOR_W-1:0] c1,
			logic [COLOR_W-1:0] c2, logic [FRAC_IN_W-1:0] tin);
		hcb_hsv_t a, b;
		longint one, t, h, s, v, i, f, sf, p, q, u, r, g, bl;
		one = longint'(1) << FBITS;
		t = tin;
		if (t > one) t = one;
		a = hsv_of_color(c1);
		b = hsv_of_color(c2);
		h = (longint'(a.h) * (one - t) + longint'(b.h) * t) >> FBITS;
		s = (longint'(a.s) * (one - t) + longint'(b.s) * t) >> FBITS;
		v = (longint'(a.v) * (one - t) + longint'(b.v) * t) >> FBITS;
		if (s > 65536) s = 65536;
		if (v > 65536) v = 65536;
		if (h >= 92160) h = 92159;
		if (s == 0) begin
			r = to_chan(v);
			return {r[7:0], r[7:0], r[7:0]};
		end
		i = h / 15360;
		f = h % 15360;
		sf = (s * f) / 15360;
		p = (v * (65536 - s)) >> 16;
		q = (v * (65536 - sf)) >> 16;
		u = (v * (65536 - s + sf)) >> 16;
		case (i)
			0: begin r = v; g = u; bl = p; end
			1: begin r = q; g = v; bl = p; end
			2: begin r = p; g = v; bl = u; end
			3: begin r = p; g = q; bl = v; end
			4: begin r = u; g = p; bl = v; end
			default: begin r = v; g = p; bl = q; end
		endcase
		r = to_chan(r);
		g = to_chan(g);
		bl = to_chan(bl);
		return {r[7:0], g[7:0], bl[7:0]};
	endfunction

	// gap length: mostly none or short, occasionally long
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [COLOR_W-1:0] random_color();
		int k;
		logic [7:0] ch[3];
		k = $urandom_range(0, 9);
		foreach (ch[j]) ch[j] = 8'($urandom);
		if (k == 0) begin
			ch[1] = ch[0];
			ch[2] = ch[0];
		end else if (k == 1) begin
			ch[$urandom_range(0, 2)] = ch[$urandom_range(0, 2)];
		end else if (k == 2) begin
			ch[$urandom_range(0, 2)] = 8'hff;
			ch[$urandom_range(0, 2)] = 8'h00;
		end
		return {ch[0], ch[1], ch[2]};
	endfunction

	function automatic logic [FRAC_IN_W-1:0] random_fraction();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) return '0;
		if (k == 1) return 17'h10000;
		if (k == 2) return FRAC_IN_W'($urandom_range(65537, 131071));
		return FRAC_IN_W'($urandom_range(0, 65535));
	endfunction

	// one transaction: hold start until accepted
	task automatic send_blend(logic [COLOR_W-1:0] c1, logic [COLOR_W-1:0] c2,
			logic [FRAC_IN_W-1:0] t, logic known, logic [COLOR_W-1:0] res);
		logic [COLOR_W-1:0] pred;
		pred = blend_colors(c1, c2, t);
		if (known && pred !== res) begin
			$error("table row blended_color: expected %h, predictor %h", res, pred);
			fail_count++;
		end
		start <= 1'b1;
		first_color <= c1;
		second_color <= c2;
		blend_fraction <= t;
		do @(posedge clk); while (busy);
		expected_colors.push_back(known ? res : pred);
		@(negedge clk);
	endtask

	// directed table then random stimulus
	initial begin
		blend_row_t rows[$];
		int gap;
		start = 1'b0;
		first_color = '0;
		second_color = '0;
		blend_fraction = '0;
		fail_count = 0;
		stim_done = 0;
		arst_n = 1'b0;
		rows = '{
			'{24'h000000, 24'h000000, 17'h00000, 1, 24'h000000},
			'{24'hffffff, 24'hffffff, 17'h08000, 1, 24'hffffff},
			'{24'h000000, 24'hffffff, 17'h10000, 1, 24'hffffff},
			'{24'hffffff, 24'h000000, 17'h1ffff, 1, 24'h000000},
			'{24'hff0000, 24'h00ff00, 17'h00000, 1, 24'hff0000},
			'{24'hff0000, 24'h00ff00, 17'h10000, 1, 24'h00ff00},
			'{24'h0000ff, 24'hff0000, 17'h10001, 1, 24'hff0000},
			'{24'h808080, 24'h808080, 17'h04000, 1, 24'h808080},
			'{24'hff0000, 24'h0000ff, 17'h08000, 0, 24'h0},
			'{24'hffff00, 24'h00ffff, 17'h08000, 0, 24'h0},
			'{24'hff00ff, 24'h00ff00, 17'h0c000, 0, 24'h0},
			'{24'hff0080, 24'h80ff00, 17'h02000, 0, 24'h0},
			'{24'h0080ff, 24'hff8000, 17'h0ffff, 0, 24'h0},
			'{24'h00ff80, 24'h8000ff, 17'h00001, 0, 24'h0},
			'{24'h123456, 24'hfedcba, 17'h05555, 0, 24'h0},
			'{24'h000000, 24'hff0000, 17'h08000, 0, 24'h0},
			'{24'h404040, 24'h00ff00, 17'h08000, 0, 24'h0},
			'{24'hffff00, 24'hff00ff, 17'h1aaaa, 0, 24'h0},
			'{24'h01fe7f, 24'hfe0180, 17'h0aaaa, 0, 24'h0}
		};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[i])
			send_blend(rows[i].c1, rows[i].c2, rows[i].t, rows[i].known, rows[i].res);
		for (int n = 0; n < N_RANDOM; n++) begin
			gap = pick_gap();
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			send_blend(random_color(), random_color(), random_fraction(), 0, '0);
		end
		start <= 1'b0;
		stim_done = 1;
	end

	// result checking
	always @(posedge clk) begin
		logic [COLOR_W-1:0] exp_color;
		if (arst_n && strobe) begin
			if (expected_colors.size() == 0) begin
				$error("unexpected transaction: blended_color %h", blended_color);
				fail_count++;
			end else begin
				exp_color = expected_colors.pop_front();
				if (blended_color !== exp_color) begin
					$error("blended_color: expected %h, actual %h", exp_color,
						blended_color);
					fail_count++;
				end
			end
		end
	end

	// watchdog on accepted transactions and strobes, and the final verdict
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((start && !busy) || strobe) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("** hsv_color_blender: FAILED **");
				$finish;
			end
			if (stim_done && expected_colors.size() == 0) begin
				repeat (DRAIN_WAIT) @(posedge clk);
				if (fail_count == 0 && expected_colors.size() == 0)
					$display("** hsv_color_blender: PASSED **");
				else begin
					if (expected_colors.size() != 0)
						$error("%0d transactions never returned", expected_colors.size());
					$display("** hsv_color_blender: FAILED **");
				end
				$finish;
			end
		end
	end

endmodule
